// ===== design/x86ae_pkg.sv =====
`default_nettype none

package x86ae_pkg;

    localparam int unsigned NumRegs = 8;

    // flag bit positions
    localparam int unsigned FlagCf = 0;
    localparam int unsigned FlagPf = 2;
    localparam int unsigned FlagZf = 6;
    localparam int unsigned FlagSf = 7;
    localparam int unsigned FlagOf = 11;

    localparam logic [15:0] FlagsArith = 16'h08C5;

    // opcode classes
    localparam logic [5:0] OpcGroupImm = 6'b100000;
    localparam logic [6:0] OpcIncRm    = 7'b1111111;
    localparam logic [4:0] OpcIncReg   = 5'b01000;
    localparam logic [2:0] OpcAccImm   = 3'b010;
    localparam logic [7:0] OpcGrpWord  = 8'h81;
    localparam logic [7:0] OpcGrpSext  = 8'h83;

    // modrm reg field in group forms
    localparam logic [2:0] RegFieldAdd = 3'd0;
    localparam logic [2:0] RegFieldAdc = 3'd2;

    localparam logic [1:0] ModDisp0 = 2'd0;
    localparam logic [1:0] ModDisp8 = 2'd1;
    localparam logic [1:0] ModDisp16 = 2'd2;
    localparam logic [1:0] ModReg   = 2'd3;
    localparam logic [2:0] RmDirect = 3'd6;

    typedef logic [NumRegs-1:0][15:0] t_regs;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [7:0]  instr_byte1;
        logic [7:0]  instr_byte2;
        logic [7:0]  instr_byte3;
        logic [7:0]  instr_byte4;
        logic [7:0]  instr_byte5;
        logic [15:0] mem_operand;
    } t_in_item;

    typedef struct packed {
        logic        handled;
        logic [15:0] result_value;
        logic        word_op;
        logic        mem_write;
        logic [15:0] flags_word;
        logic [2:0]  instr_length;
        logic [15:0] next_ip;
    } t_out_item;

    // state update produced by one instruction
    typedef struct packed {
        logic        reg_we;
        logic        reg_word;
        logic [2:0]  reg_idx;
        logic [15:0] reg_value;
        logic        state_we;
        logic [15:0] flags;
        logic [15:0] ip;
    } t_wb;

    function automatic logic [15:0] read_reg(t_regs regs, logic [2:0] idx, logic word);
        logic [15:0] v;
        v = regs[{1'b0, idx[1:0]}];
        if (word) begin
            return regs[idx];
        end else if (idx[2]) begin
            return {8'h00, v[15:8]};
        end
        return {8'h00, v[7:0]};
    endfunction

endpackage

`default_nettype wire

// ===== design/x86ae_exec.sv =====
`default_nettype none

module x86ae_exec (
    input  wire x86ae_pkg::t_in_item  i_item,
    input  wire x86ae_pkg::t_regs     i_regs,
    input  wire logic [15:0]          i_flags,
    input  wire logic [15:0]          i_ip,
    output x86ae_pkg::t_out_item      o_item,
    output x86ae_pkg::t_wb            o_wb
);
    import x86ae_pkg::*;

    logic [7:0]  opc;
    logic [1:0]  mod_f;
    logic [2:0]  reg_f;
    logic [2:0]  rm_f;
    logic [2:0]  dlen;
    logic        cf_in;
    logic        is_rm;
    logic        is_acc;
    logic        is_grp;
    logic        is_incrm;
    logic        is_increg;
    logic        handled;
    logic        word;
    logic [15:0] opa;
    logic [15:0] opb;
    logic        cin;
    logic        keep_cf;
    logic [15:0] imm;
    logic [2:0]  ilen;
    logic [2:0]  len;
    logic [8:0]  sum8;
    logic [16:0] sum16;
    logic [15:0] res;
    logic        cf;
    logic        of;
    logic        sf;
    logic [15:0] flags_new;
    logic [15:0] memop;
    logic        memw;
    logic        reg_we;
    logic [2:0]  wb_idx;

    always_comb begin
        opc   = i_item.cmd;
        mod_f = i_item.instr_byte1[7:6];
        reg_f = i_item.instr_byte1[5:3];
        rm_f  = i_item.instr_byte1[2:0];
        cf_in = i_flags[FlagCf];

        case (mod_f)
            ModDisp8:  dlen = 3'd1;
            ModDisp16: dlen = 3'd2;
            ModDisp0:  dlen = (rm_f == RmDirect) ? 3'd2 : 3'd0;
            default:   dlen = 3'd0;
        endcase

        is_rm     = (opc[7:5] == 3'b000) && (opc[3:2] == 2'b00);
        is_acc    = (opc[7:5] == 3'b000) && (opc[3:1] == OpcAccImm);
        is_grp    = (opc[7:2] == OpcGroupImm) &&
                    ((reg_f == RegFieldAdd) || (reg_f == RegFieldAdc));
        is_incrm  = (opc[7:1] == OpcIncRm) && (reg_f == RegFieldAdd);
        is_increg = (opc[7:3] == OpcIncReg);
        handled   = is_rm || is_acc || is_grp || is_incrm || is_increg;

        word  = is_increg ? 1'b1 : opc[0];
        memop = word ? i_item.mem_operand : {8'h00, i_item.mem_operand[7:0]};

        // immediate of the group forms follows the displacement
        case (dlen)
            3'd1:    imm = {i_item.instr_byte4, i_item.instr_byte3};
            3'd2:    imm = {i_item.instr_byte5, i_item.instr_byte4};
            default: imm = {i_item.instr_byte3, i_item.instr_byte2};
        endcase
        if (opc == OpcGrpWord) begin
            ilen = 3'd2;
        end else if (opc == OpcGrpSext) begin
            imm  = {{8{imm[7]}}, imm[7:0]};
            ilen = 3'd1;
        end else begin
            imm  = {8'h00, imm[7:0]};
            ilen = 3'd1;
        end

        opa     = '0;
        opb     = '0;
        cin     = 1'b0;
        keep_cf = 1'b0;
        len     = '0;
        memw    = 1'b0;
        reg_we  = 1'b0;
        wb_idx  = rm_f;
        if (is_rm) begin
            opa    = (mod_f == ModReg) ? read_reg(i_regs, rm_f, word) : memop;
            opb    = read_reg(i_regs, reg_f, word);
            cin    = opc[4] & cf_in;
            len    = 3'd2 + dlen;
            if (opc[1]) begin
                reg_we = 1'b1;
                wb_idx = reg_f;
            end else begin
                reg_we = (mod_f == ModReg);
                memw   = (mod_f != ModReg);
            end
        end else if (is_acc) begin
            opa    = read_reg(i_regs, 3'd0, word);
            opb    = word ? {i_item.instr_byte2, i_item.instr_byte1}
                          : {8'h00, i_item.instr_byte1};
            cin    = opc[4] & cf_in;
            len    = word ? 3'd3 : 3'd2;
            reg_we = 1'b1;
            wb_idx = 3'd0;
        end else if (is_grp || is_incrm) begin
            opa     = (mod_f == ModReg) ? read_reg(i_regs, rm_f, word) : memop;
            opb     = is_grp ? imm : 16'd1;
            cin     = is_grp && (reg_f == RegFieldAdc) && cf_in;
            keep_cf = is_incrm;
            len     = 3'd2 + dlen + (is_grp ? ilen : 3'd0);
            reg_we  = (mod_f == ModReg);
            memw    = (mod_f != ModReg);
        end else if (is_increg) begin
            opa     = read_reg(i_regs, opc[2:0], 1'b1);
            opb     = 16'd1;
            keep_cf = 1'b1;
            len     = 3'd1;
            reg_we  = 1'b1;
            wb_idx  = opc[2:0];
        end

        sum8  = {1'b0, opa[7:0]} + {1'b0, opb[7:0]} + {8'h00, cin};
        sum16 = {1'b0, opa} + {1'b0, opb} + {16'h0000, cin};
        if (word) begin
            res = sum16[15:0];
            cf  = sum16[16];
            of  = ~(opa[15] ^ opb[15]) & (opa[15] ^ res[15]);
            sf  = res[15];
        end else begin
            res = {8'h00, sum8[7:0]};
            cf  = sum8[8];
            of  = ~(opa[7] ^ opb[7]) & (opa[7] ^ res[7]);
            sf  = res[7];
        end

        flags_new         = i_flags & ~FlagsArith;
        flags_new[FlagCf] = keep_cf ? cf_in : cf;
        flags_new[FlagPf] = ~^res[7:0];
        flags_new[FlagZf] = (res == 16'h0000);
        flags_new[FlagSf] = sf;
        flags_new[FlagOf] = of;

        o_item.handled      = handled;
        o_item.result_value = handled ? res : 16'h0000;
        o_item.word_op      = handled & word;
        o_item.mem_write    = handled & memw;
        o_item.flags_word   = handled ? flags_new : i_flags;
        o_item.instr_length = handled ? len : 3'd0;
        o_item.next_ip      = handled ? (i_ip + {13'd0, len}) : i_ip;

        o_wb.reg_we    = handled & reg_we;
        o_wb.reg_word  = word;
        o_wb.reg_idx   = wb_idx;
        o_wb.reg_value = res;
        o_wb.state_we  = handled;
        o_wb.flags     = flags_new;
        o_wb.ip        = i_ip + {13'd0, len};
    end

endmodule

`default_nettype wire

// ===== design/x86_add_adc_inc_execute.sv =====
`default_nettype none

// 16-bit x86 ADD/ADC/INC execute stage. One instruction per transfer, one
// result per instruction; a new instruction is taken every cycle unless the
// output stalls. The instruction is registered; decode, add and flag logic
// run in one pass into the result register. The register file, flags and IP
// are updated on the same edge that loads the result, so the next instruction
// already sees them. Memory operands come in on mem_operand; a memory
// destination is reported through mem_write with the sum on result_value.
module x86_add_adc_inc_execute (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire x86ae_pkg::t_in_item  i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output x86ae_pkg::t_out_item      o_out_item
);
    import x86ae_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_regs      r_regs;
    logic [15:0] r_flags;
    logic [15:0] r_ip;

    t_out_item  exec_item;
    t_wb        exec_wb;
    logic       advance;
    logic       retire;
    logic [15:0] wr_old;
    logic [15:0] n_reg_val;
    logic [1:0]  n_reg_idx;

    x86ae_exec u_exec (
        .i_item  (r_in_item),
        .i_regs  (r_regs),
        .i_flags (r_flags),
        .i_ip    (r_ip),
        .o_item  (exec_item),
        .o_wb    (exec_wb)
    );

    // result register free or draining this cycle
    assign advance     = !r_out_valid || !i_out_stall;
    assign retire      = advance && r_in_valid;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // byte writes merge into one half of a word register
    always_comb begin
        n_reg_idx = exec_wb.reg_idx[1:0];
        wr_old    = r_regs[{1'b0, n_reg_idx}];
        if (exec_wb.reg_word) begin
            n_reg_val = exec_wb.reg_value;
        end else if (exec_wb.reg_idx[2]) begin
            n_reg_val = {exec_wb.reg_value[7:0], wr_old[7:0]};
        end else begin
            n_reg_val = {wr_old[15:8], exec_wb.reg_value[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '0;
            r_flags     <= '0;
            r_ip        <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (retire && exec_wb.state_we) begin
                r_flags <= exec_wb.flags;
                r_ip    <= exec_wb.ip;
            end
            if (retire && exec_wb.reg_we) begin
                if (exec_wb.reg_word) begin
                    r_regs[exec_wb.reg_idx] <= n_reg_val;
                end else begin
                    r_regs[{1'b0, n_reg_idx}] <= n_reg_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (retire) begin
            r_out_item <= exec_item;
        end
    end

    // a retired instruction leaves its IP in the state and its result valid
    a_ip_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        retire |=> (r_out_valid && (r_ip == o_out_item.next_ip)))
        else $error("ip state does not match retired result");

    a_flags_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        retire |=> (r_flags == o_out_item.flags_word))
        else $error("flags state does not match retired result");

    a_flags_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.flags_word & ~FlagsArith) == 16'h0000))
        else $error("non-arithmetic flag bit set");

    a_unhandled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.handled) |->
            ((o_out_item.instr_length == 3'd0) && !o_out_item.mem_write &&
             !o_out_item.word_op))
        else $error("unhandled form reports an effect");

endmodule

`default_nettype wire

// ===== test/x86_add_adc_inc_execute_check.sv =====
module x86_add_adc_inc_execute_check (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire x86ae_pkg::t_in_item  i_in_item,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire x86ae_pkg::t_out_item i_out_item,
    output int                        o_mismatches,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import x86ae_pkg::*;

    // opcode pages 00-03/10-13: add/adc with modrm
    localparam logic [2:0] OpcAluPage   = 3'b000;
    localparam logic [1:0] OpcAluRmForm = 2'b00;
    localparam logic [2:0] RegAx        = 3'd0;

    logic [15:0] gpr [NumRegs];
    logic [15:0] flags_q;
    logic [15:0] ip_q;
    t_out_item   expected_results [$];
    int          mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [15:0] reg_get(logic [2:0] idx, logic word);
        logic [15:0] pair;
        pair = gpr[{1'b0, idx[1:0]}];
        if (word) begin
            return gpr[idx];
        end
        // byte regs 4-7 are the high halves of ax..bx
        return idx[2] ? {8'h00, pair[15:8]} : {8'h00, pair[7:0]};
    endfunction

    task automatic reg_put(input logic [2:0] idx, input logic word, input logic [15:0] value);
        if (word) begin
            gpr[idx] = value;
        end else if (idx[2]) begin
            gpr[{1'b0, idx[1:0]}][15:8] = value[7:0];
        end else begin
            gpr[{1'b0, idx[1:0]}][7:0] = value[7:0];
        end
    endtask

    task automatic add_with_flags(input logic [15:0] a, input logic [15:0] b, input logic cin,
                                  input logic word, input logic keep_cf,
                                  output logic [15:0] sum);
        logic [16:0] full;
        logic        carry;
        logic        ovf;
        logic        neg;
        logic        zero;
        if (word) begin
            full  = {1'b0, a} + {1'b0, b} + 17'(cin);
            sum   = full[15:0];
            carry = full[16];
            ovf   = (a[15] == b[15]) && (sum[15] != a[15]);
            neg   = sum[15];
            zero  = (sum == 16'h0000);
        end else begin
            full  = {9'd0, a[7:0]} + {9'd0, b[7:0]} + 17'(cin);
            sum   = {8'h00, full[7:0]};
            carry = full[8];
            ovf   = (a[7] == b[7]) && (sum[7] != a[7]);
            neg   = sum[7];
            zero  = (sum[7:0] == 8'h00);
        end
        if (!keep_cf) begin
            flags_q[FlagCf] = carry;
        end
        flags_q[FlagOf] = ovf;
        flags_q[FlagSf] = neg;
        flags_q[FlagZf] = zero;
        flags_q[FlagPf] = ~^sum[7:0];
    endtask

    task automatic execute_instr(input t_in_item instr, output t_out_item outcome);
        logic [7:0]  opc;
        logic [1:0]  md;
        logic [2:0]  rg;
        logic [2:0]  rm;
        logic [7:0]  ib [6];
        logic [15:0] operand;
        logic [15:0] imm;
        logic [15:0] sum;
        logic [2:0]  len;
        logic        cin;
        logic        word;
        logic        done;
        logic        to_mem;
        int          dlen;
        int          ipos;
        opc    = instr.cmd;
        md     = instr.instr_byte1[7:6];
        rg     = instr.instr_byte1[5:3];
        rm     = instr.instr_byte1[2:0];
        ib[0]  = instr.cmd;
        ib[1]  = instr.instr_byte1;
        ib[2]  = instr.instr_byte2;
        ib[3]  = instr.instr_byte3;
        ib[4]  = instr.instr_byte4;
        ib[5]  = instr.instr_byte5;
        dlen   = (md == ModDisp8) ? 1 : (md == ModDisp16) ? 2 :
                 (md == ModDisp0 && rm == RmDirect) ? 2 : 0;
        word   = opc[0];
        // memory operand is zero-extended for byte forms
        operand = (md == ModReg) ? reg_get(rm, word) :
                  word ? instr.mem_operand : {8'h00, instr.mem_operand[7:0]};
        sum    = '0;
        len    = '0;
        done   = 1'b1;
        to_mem = 1'b0;

        if (opc[7:5] == OpcAluPage && opc[3:2] == OpcAluRmForm) begin
            cin = opc[4] & flags_q[FlagCf];
            add_with_flags(operand, reg_get(rg, word), cin, word, 1'b0, sum);
            if (opc[1]) begin
                reg_put(rg, word, sum);
            end else if (md == ModReg) begin
                reg_put(rm, word, sum);
            end else begin
                to_mem = 1'b1;
            end
            len = 3'(2 + dlen);
        end else if (opc[7:5] == OpcAluPage && opc[3:1] == OpcAccImm) begin
            cin = opc[4] & flags_q[FlagCf];
            imm = word ? {ib[2], ib[1]} : {8'h00, ib[1]};
            add_with_flags(reg_get(RegAx, word), imm, cin, word, 1'b0, sum);
            reg_put(RegAx, word, sum);
            len = word ? 3'd3 : 3'd2;
        end else if (opc[7:2] == OpcGroupImm && (rg == RegFieldAdd || rg == RegFieldAdc)) begin
            cin  = (rg == RegFieldAdc) & flags_q[FlagCf];
            ipos = 2 + dlen;
            if (opc == OpcGrpWord) begin
                imm = {ib[ipos + 1], ib[ipos]};
            end else if (opc == OpcGrpSext) begin
                imm = {{8{ib[ipos][7]}}, ib[ipos]};
            end else begin
                imm = {8'h00, ib[ipos]};
            end
            add_with_flags(operand, imm, cin, word, 1'b0, sum);
            if (md == ModReg) begin
                reg_put(rm, word, sum);
            end else begin
                to_mem = 1'b1;
            end
            len = 3'(2 + dlen + ((opc == OpcGrpWord) ? 2 : 1));
        end else if (opc[7:1] == OpcIncRm && rg == RegFieldAdd) begin
            add_with_flags(operand, 16'h0001, 1'b0, word, 1'b1, sum);
            if (md == ModReg) begin
                reg_put(rm, word, sum);
            end else begin
                to_mem = 1'b1;
            end
            len = 3'(2 + dlen);
        end else if (opc[7:3] == OpcIncReg) begin
            word = 1'b1;
            add_with_flags(reg_get(opc[2:0], 1'b1), 16'h0001, 1'b0, 1'b1, 1'b1, sum);
            reg_put(opc[2:0], 1'b1, sum);
            len = 3'd1;
        end else begin
            done = 1'b0;
        end

        if (done) begin
            ip_q = ip_q + 16'(len);
        end
        outcome.handled      = done;
        outcome.result_value = sum;
        outcome.word_op      = done & word;
        outcome.mem_write    = to_mem;
        outcome.flags_word   = flags_q;
        outcome.instr_length = len;
        outcome.next_ip      = ip_q;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            foreach (gpr[k]) begin
                gpr[k] = '0;
            end
            flags_q = '0;
            ip_q    = '0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: result with none expected: %p", $realtime, got);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.handled !== want.handled
                            || got.result_value !== want.result_value
                            || got.word_op !== want.word_op
                            || got.mem_write !== want.mem_write
                            || got.flags_word !== want.flags_word
                            || got.instr_length !== want.instr_length
                            || got.next_ip !== want.next_ip) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: mismatch expected %p", $realtime, want);
                            $display("%0t:          actual   %p", $realtime, got);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                execute_instr(i_in_item, want);
                expected_results.push_back(want);
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

// ===== test/x86_add_adc_inc_execute_test.sv =====
module x86_add_adc_inc_execute_test;
    timeunit 1ns;
    timeprecision 1ps;

    import x86ae_pkg::*;

    localparam int HalfPeriod  = 5;
    localparam int IdleLimit   = 200;
    localparam int RandomItems = 1500;
    // six-byte group word forms with a 16-bit displacement
    localparam int LongItems   = 300;

    localparam logic [7:0] OpAddRmB    = 8'h00;
    localparam logic [7:0] OpAddRmW    = 8'h01;
    localparam logic [7:0] OpAddRegB   = 8'h02;
    localparam logic [7:0] OpAdcRmB    = 8'h10;
    localparam logic [7:0] OpAdcRegW   = 8'h13;
    localparam logic [7:0] OpAddAlImm  = 8'h04;
    localparam logic [7:0] OpAddAxImm  = 8'h05;
    localparam logic [7:0] OpAdcAlImm  = 8'h14;
    localparam logic [7:0] OpAdcAxImm  = 8'h15;
    localparam logic [7:0] OpGrpByte   = 8'h80;
    localparam logic [7:0] OpGrpByteAl = 8'h82;
    localparam logic [7:0] OpIncByte   = 8'hFE;
    localparam logic [7:0] OpIncWord   = 8'hFF;
    localparam logic [7:0] OpIncAx     = 8'h40;
    localparam logic [7:0] OpIncDi     = 8'h47;
    localparam logic [7:0] OpNop       = 8'h90;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    int        mismatches;
    int        pending;
    bit        no_gaps = 1'b0;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    always #HalfPeriod clk = ~clk;

    x86_add_adc_inc_execute i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    x86_add_adc_inc_execute_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: return 8'h00;
                1: return 8'h7F;
                2: return 8'h80;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_mem();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 5))
                0: return 16'h0000;
                1: return 16'h007F;
                2: return 16'h00FF;
                3: return 16'h7FFF;
                4: return 16'h8000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic t_in_item mk(logic [7:0] op, logic [7:0] b1, logic [7:0] b2,
                                    logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                    logic [15:0] mem);
        t_in_item it;
        it.cmd         = op;
        it.instr_byte1 = b1;
        it.instr_byte2 = b2;
        it.instr_byte3 = b3;
        it.instr_byte4 = b4;
        it.instr_byte5 = b5;
        it.mem_operand = mem;
        return it;
    endfunction

    // mostly supported forms with random operands, some odd reg fields and raw opcodes
    function automatic t_in_item rand_instr();
        t_in_item   it;
        int         pick;
        logic       adc;
        logic [2:0] field;
        it   = mk(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rand_byte(),
                  rand_byte(), rand_byte(), rand_byte(), rand_mem());
        pick = $urandom_range(0, 99);
        adc  = 1'($urandom_range(0, 1));
        field = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
                adc ? RegFieldAdc : RegFieldAdd;
        if (pick < 25) begin
            it.cmd = (adc ? OpAdcRmB : OpAddRmB) | 8'($urandom_range(0, 3));
        end else if (pick < 37) begin
            it.cmd = (adc ? OpAdcAlImm : OpAddAlImm) | 8'($urandom_range(0, 1));
        end else if (pick < 65) begin
            it.cmd = {OpcGroupImm, 2'($urandom_range(0, 3))};
            it.instr_byte1[5:3] = field;
        end else if (pick < 80) begin
            it.cmd = {OpcIncRm, 1'($urandom_range(0, 1))};
            it.instr_byte1[5:3] = ($urandom_range(0, 7) == 0) ? field : RegFieldAdd;
        end else if (pick < 92) begin
            it.cmd = {OpcIncReg, 3'($urandom_range(0, 7))};
        end
        return it;
    endfunction

    task automatic send_instr(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (out_valid && !out_stall) begin
            // hold-off before the next result transfer
            stall_left = pick_gap();
            out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IdleLimit) begin
            $display("x86_add_adc_inc_execute verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_instr(mk(OpAddAxImm, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpIncAx, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpAddAxImm, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpAdcAxImm, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpAddAlImm, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpAdcAlImm, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        // al/ah pairs read the high half of ax
        send_instr(mk(OpAddRegB, 8'hC4, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpAddRmB, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpAddRmW, 8'h06, 8'h34, 8'h12, 8'h00, 8'h00, 16'hFFFF));
        send_instr(mk(OpAdcRegW, 8'h46, 8'h10, 8'h00, 8'h00, 8'h00, 16'h8000));
        send_instr(mk(OpcGrpWord, 8'h86, 8'h34, 8'h12, 8'hFF, 8'h7F, 16'h0001));
        send_instr(mk(OpcGrpSext, 8'hC1, 8'h80, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpcGrpSext, 8'hD1, 8'h7F, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpGrpByteAl, 8'hC7, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpGrpByte, 8'h16, 8'h00, 8'h10, 8'h01, 8'h00, 16'h00FF));
        send_instr(mk(OpIncByte, 8'h06, 8'h00, 8'h20, 8'h00, 8'h00, 16'h007F));
        send_instr(mk(OpIncWord, 8'hC2, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpIncByte, 8'hC4, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpIncWord, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF));
        send_instr(mk(OpIncWord, 8'h06, 8'h00, 8'h30, 8'h00, 8'h00, 16'h7FFF));
        // unsupported: group /1, fe /1, and a plain opcode
        send_instr(mk(OpGrpByte, 8'hC8, 8'h12, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpIncByte, 8'hC8, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpNop, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_instr(mk(OpIncDi, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));

        // long six-byte group forms, random content
        for (int n = 0; n < LongItems; n++) begin
            if (n % 100 == 0) begin
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            send_instr(mk(OpcGrpWord,
                          {ModDisp16, $urandom_range(0, 1) ? RegFieldAdc : RegFieldAdd,
                           3'($urandom_range(0, 7))},
                          rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_mem()));
        end

        for (int n = 0; n < RandomItems; n++) begin
            if (n % 150 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            send_instr(rand_instr());
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        if (mismatches == 0) begin
            $display("x86_add_adc_inc_execute verification clean");
        end else begin
            $display("x86_add_adc_inc_execute verification failed");
        end
        $finish;
    end

endmodule

// ===== x86_add_adc_inc_execute.f =====
design/x86ae_pkg.sv
design/x86ae_exec.sv
design/x86_add_adc_inc_execute.sv
test/x86_add_adc_inc_execute_check.sv
test/x86_add_adc_inc_execute_test.sv
